[sv/u2u_pkg.sv]
`timescale 1ns / 1ps

package u2u_pkg;

    // Unit values
    localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
    localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0]  LO_SURR_TAG   = 6'b110111;   // 0xDC00 >> 10
    localparam logic [4:0]  SURR_TOP      = 5'b11011;    // 0xD800..0xDFFF
    localparam logic [20:0] CP_LIMIT      = 21'h110000;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;

    // Lead byte ranges
    localparam logic [7:0]  LEAD_MIN      = 8'hC2;
    localparam logic [7:0]  LEAD_END      = 8'hF8;
    localparam logic [7:0]  LEAD_3B       = 8'hE0;
    localparam logic [7:0]  LEAD_4B       = 8'hF0;

    // Depth of the queue between decode and unit sequencer
    localparam int DEF_FIFO_DEPTH = 4;

    // One decoded request: a run of replacement units, then up to two
    // decoded units, then an optional terminator.
    typedef struct packed {
        logic [2:0]  rep_cnt;
        logic [1:0]  main_cnt;
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        term;
    } t_desc;

endpackage

[sv/u2u_front.sv]
`timescale 1ns / 1ps

module u2u_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_string,
    output logic            o_wr,
    output u2u_pkg::t_desc  o_desc
);
    import u2u_pkg::*;

    logic [7:0]  r_lead,    n_lead;
    logic [1:0]  r_held,    n_held;
    logic [11:0] r_payload, n_payload;
    logic        r_stopped, n_stopped;

    logic        cont_ok;
    logic        start;
    logic [1:0]  need;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [19:0] supp;
    t_desc       desc;

    assign cp2  = {r_lead[4:0], i_data_byte[5:0]};
    assign cp3  = {r_lead[3:0], r_payload[5:0], i_data_byte[5:0]};
    assign cp4  = {r_lead[2:0], r_payload, i_data_byte[5:0]};
    assign supp = 20'(cp4 - SUPP_BASE);

    always_comb begin
        n_lead    = r_lead;
        n_held    = r_held;
        n_payload = r_payload;
        n_stopped = r_stopped;
        desc      = '0;
        start     = 1'b0;
        cont_ok   = (i_data_byte[7:6] == 2'b10);
        if (r_lead < LEAD_3B) begin
            need = 2'd1;
        end else if (r_lead < LEAD_4B) begin
            need = 2'd2;
        end else begin
            need = 2'd3;
        end

        // Reject overlong three and four byte forms on the second byte
        if (r_held == 2'd0) begin
            if (r_lead == LEAD_3B) begin
                cont_ok = cont_ok & i_data_byte[5];
            end else if (r_lead == LEAD_4B) begin
                cont_ok = cont_ok & (i_data_byte[5] | i_data_byte[4]);
            end
        end

        if (!r_stopped) begin
            if (r_lead != 8'd0) begin
                if (!cont_ok) begin
                    // Broken sequence: replace lead and held bytes, then restart
                    desc.rep_cnt = 3'(r_held) + 3'd1;
                    n_lead       = '0;
                    n_held       = '0;
                    n_payload    = '0;
                    start        = 1'b1;
                end else if ((3'(r_held) + 3'd1) < 3'(need)) begin
                    n_payload = {r_payload[5:0], i_data_byte[5:0]};
                    n_held    = r_held + 2'd1;
                end else begin
                    desc.main_cnt = 2'd1;
                    if (need == 2'd1) begin
                        desc.unit0 = 16'(cp2);
                    end else if (need == 2'd2) begin
                        desc.unit0 = (cp3[15:11] == SURR_TOP) ? REPLACEMENT : cp3;
                    end else if (cp4 < CP_LIMIT) begin
                        desc.main_cnt = 2'd2;
                        desc.unit0    = {HI_SURR_TAG, supp[19:10]};
                        desc.unit1    = {LO_SURR_TAG, supp[9:0]};
                    end else begin
                        desc.unit0 = REPLACEMENT;
                    end
                    n_lead    = '0;
                    n_held    = '0;
                    n_payload = '0;
                end
            end else begin
                start = 1'b1;
            end

            if (start) begin
                priority if (i_data_byte == 8'd0) begin
                    n_stopped = 1'b1;
                end else if (!i_data_byte[7]) begin
                    desc.main_cnt = 2'd1;
                    desc.unit0    = 16'(i_data_byte);
                end else if (i_data_byte >= LEAD_MIN && i_data_byte < LEAD_END) begin
                    n_lead    = i_data_byte;
                    n_held    = '0;
                    n_payload = '0;
                end else begin
                    desc.main_cnt = 2'd1;
                    desc.unit0    = REPLACEMENT;
                end
            end
        end

        // End of string: flush what is still pending, close with a terminator
        if (i_end_of_string) begin
            if (n_lead != 8'd0) begin
                desc.rep_cnt = desc.rep_cnt + 3'(n_held) + 3'd1;
            end
            desc.term = 1'b1;
            n_lead    = '0;
            n_held    = '0;
            n_payload = '0;
            n_stopped = 1'b0;
        end
    end

    assign o_desc = desc;
    assign o_wr   = i_accept &&
                    (desc.rep_cnt != 3'd0 || desc.main_cnt != 2'd0 || desc.term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_held    <= '0;
            r_payload <= '0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_lead    <= n_lead;
            r_held    <= n_held;
            r_payload <= n_payload;
            r_stopped <= n_stopped;
        end
    end

endmodule

[sv/u2u_fifo.sv]
`timescale 1ns / 1ps

module u2u_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[sv/u2u_back.sv]
`timescale 1ns / 1ps

module u2u_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  u2u_pkg::t_desc  i_desc,
    output logic            o_q_rd,
    input  logic            i_pop,
    output logic            o_valid,
    output logic [15:0]     o_code_unit,
    output logic            o_terminator,
    output logic            o_last_of_run
);
    import u2u_pkg::*;

    logic [2:0]  r_idx;
    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_term;
    logic        r_last;

    logic [2:0]  total;
    logic [2:0]  main_idx;
    logic        is_last;
    logic        load;
    logic [15:0] sel_unit;
    logic        sel_term;

    assign total    = i_desc.rep_cnt + 3'(i_desc.main_cnt) + 3'(i_desc.term);
    assign main_idx = r_idx - i_desc.rep_cnt;
    assign is_last  = (r_idx + 3'd1) == total;
    assign load     = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd   = load && is_last;

    always_comb begin
        sel_unit = '0;
        sel_term = 1'b0;
        priority if (r_idx < i_desc.rep_cnt) begin
            sel_unit = REPLACEMENT;
        end else if (main_idx < 3'(i_desc.main_cnt)) begin
            sel_unit = (main_idx == 3'd0) ? i_desc.unit0 : i_desc.unit1;
        end else begin
            sel_term = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? 3'd0 : r_idx + 3'd1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit <= sel_unit;
            r_term <= sel_term;
            r_last <= is_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_code_unit   = r_unit;
    assign o_terminator  = r_term;
    assign o_last_of_run = r_last;

endmodule

[sv/utf8_to_utf16_decoder.sv]
`timescale 1ns / 1ps

// UTF-8 to UTF-16 stream decoder. Push one UTF-8 byte per cycle (with
// end_of_string on the final byte of a string) and pop UTF-16 code units
// from the result side; last_of_run marks the final unit caused by a byte
// and terminator marks the closing zero unit of a string. A byte is taken
// every cycle while full is low: the decode stage classifies it in that
// cycle and parks a request in a FIFO_DEPTH-entry queue. The unit sequencer
// then drains one code unit per cycle into the output register whenever
// that register is free or popped, so a byte that yields k units (0 to 5)
// holds the sequencer until all k are out. Sustained rate is one byte per
// cycle for bytes that yield at most one unit, and is otherwise set by
// the number of units the sequencer must deliver. Bytes that yield nothing
// (held continuation bytes, bytes after a zero byte) never enter the
// queue. Malformed input becomes U+FFFD; supplementary code points become surrogate pairs.
module utf8_to_utf16_decoder #(
    parameter int FIFO_DEPTH = u2u_pkg::DEF_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_code_unit,
    output logic        o_terminator,
    output logic        o_last_of_run
);
    import u2u_pkg::*;

    localparam int DESC_W = $bits(t_desc);

    logic        accept;
    logic        q_wr;
    logic        q_rd;
    logic        q_empty;
    logic        out_valid;
    t_desc       wr_desc;
    t_desc       rd_desc;
    logic [DESC_W-1:0] rd_bits;

    // Accept a byte whenever the queue has room
    assign accept = push && !full;

    u2u_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_wr            (q_wr),
        .o_desc          (wr_desc)
    );

    // Hold decoded requests so decode and unit delivery stall independently
    u2u_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (wr_desc),
        .i_rd    (q_rd),
        .o_rdata (rd_bits),
        .o_full  (full),
        .o_empty (q_empty)
    );

    assign rd_desc = rd_bits;

    // Expand each request into code units, one per cycle unless the output register is held
    u2u_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_desc        (rd_desc),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_valid       (out_valid),
        .o_code_unit   (o_code_unit),
        .o_terminator  (o_terminator),
        .o_last_of_run (o_last_of_run)
    );

    assign empty = !out_valid;

endmodule

[sv/u2u_checker.sv]
`timescale 1ns / 1ps

module u2u_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_code_unit,
    input logic        o_terminator,
    input logic        o_last_of_run
);

    // A waiting unit holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_code_unit) && $stable(o_terminator)
                          && $stable(o_last_of_run))
        else $error("result changed while stalled");

    // Nothing is offered right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result offered after reset");

    // The terminator is a zero unit and closes the run of its byte
    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_terminator |-> o_code_unit == 16'h0000 && o_last_of_run)
        else $error("bad terminator unit");

    // A high surrogate is always followed by its low half from the same byte
    a_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_code_unit[15:10] == 6'b110110 |-> !o_last_of_run && !o_terminator)
        else $error("high surrogate closes a run");

endmodule

bind utf8_to_utf16_decoder u2u_checker u_chk (.*);

[dv/utf16_unit_checker.sv]
`timescale 1ns / 1ps

module utf16_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [15:0] i_code_unit,
    input  logic        i_terminator,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_units_left,
    output int          o_bytes_seen,
    output int          o_units_seen,
    output int          o_replacements,
    output int          o_strings_closed
);

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [20:0] CP_LIMIT    = 21'h110000;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        term;
        logic        last;
    } unit_t;

    unit_t units_due[$];   // expected units, oldest first
    unit_t run_q[$];       // units caused by the current byte

    // decoder state
    logic [7:0]  pend_lead;
    logic [1:0]  pend_count;
    logic [11:0] pend_bits;
    logic        halted;

    int fails, bytes_seen, units_seen, repl_seen, strings_seen;

    function automatic void queue_unit(logic [15:0] value, logic term);
        unit_t r;
        r.code_unit = value;
        r.term      = term;
        r.last      = 1'b0;
        run_q.push_back(r);
    endfunction

    function automatic void clear_pending();
        pend_lead  = 8'h00;
        pend_count = 2'd0;
        pend_bits  = 12'h000;
    endfunction

    // Replace the held lead and each held continuation.
    function automatic void flush_pending_bytes();
        if (pend_lead != 8'h00) begin
            queue_unit(REPLACEMENT, 1'b0);
            for (int k = 0; k < int'(pend_count); k++)
                queue_unit(REPLACEMENT, 1'b0);
            clear_pending();
        end
    endfunction

    function automatic void open_sequence(logic [7:0] b);
        if (b == 8'h00)
            halted = 1'b1;
        else if (b < 8'h80)
            queue_unit({8'h00, b}, 1'b0);
        else if (b >= 8'hC2 && b <= 8'hF7) begin
            pend_lead  = b;
            pend_count = 2'd0;
            pend_bits  = 12'h000;
        end else
            queue_unit(REPLACEMENT, 1'b0);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic        ok;
        int          need;
        logic [20:0] cp;
        logic [19:0] ofs;
        if (pend_lead == 8'h00) begin
            open_sequence(b);
            return;
        end
        ok = (b[7:6] == 2'b10);
        // reject overlong three- and four-byte forms on the second byte
        if (ok && pend_count == 2'd0) begin
            if (pend_lead[7:4] == 4'hE)
                ok = (pend_lead[3:0] != 4'h0) || b[5];
            else if (pend_lead[7:4] == 4'hF)
                ok = (pend_lead[2:0] != 3'd0) || (b[5:4] != 2'b00);
        end
        if (!ok) begin
            flush_pending_bytes();
            open_sequence(b);
            return;
        end
        need = (pend_lead < 8'hE0) ? 1 : ((pend_lead < 8'hF0) ? 2 : 3);
        if (int'(pend_count) + 1 < need) begin
            pend_bits  = {pend_bits[5:0], b[5:0]};
            pend_count = pend_count + 2'd1;
            return;
        end
        if (need == 1) begin
            cp = {10'd0, pend_lead[4:0], b[5:0]};
            queue_unit(cp[15:0], 1'b0);
        end else if (need == 2) begin
            cp = {5'd0, pend_lead[3:0], pend_bits[5:0], b[5:0]};
            queue_unit((cp[15:11] == 5'b11011) ? REPLACEMENT : cp[15:0], 1'b0);
        end else begin
            cp = {pend_lead[2:0], pend_bits, b[5:0]};
            if (cp < CP_LIMIT) begin
                ofs = 20'(cp - SUPP_BASE);
                queue_unit({6'b110110, ofs[19:10]}, 1'b0);
                queue_unit({6'b110111, ofs[9:0]}, 1'b0);
            end else
                queue_unit(REPLACEMENT, 1'b0);
        end
        clear_pending();
    endfunction

    // Work out every unit one byte request causes and append them.
    function automatic void decode_request(logic [7:0] b, logic eos);
        unit_t r;
        run_q.delete();
        if (!halted) begin
            decode_byte(b);
            if (halted)
                flush_pending_bytes();
        end
        if (eos) begin
            flush_pending_bytes();
            queue_unit(16'h0000, 1'b1);
            clear_pending();
            halted = 1'b0;
        end
        if (run_q.size() > 0) begin
            r = run_q.pop_back();
            r.last = 1'b1;
            run_q.push_back(r);
        end
        foreach (run_q[i])
            units_due.push_back(run_q[i]);
    endfunction

    always @(posedge i_clk) begin
        unit_t want;
        if (!i_rst_n) begin
            clear_pending();
            halted = 1'b0;
            units_due.delete();
        end else begin
            if (i_push && !i_full) begin
                bytes_seen++;
                decode_request(i_data_byte, i_end_of_string);
            end
            if (i_pop && !i_empty) begin
                units_seen++;
                if (i_terminator)
                    strings_seen++;
                else if (i_code_unit == REPLACEMENT)
                    repl_seen++;
                if (units_due.size() == 0) begin
                    $error("code unit %h arrived with nothing expected", i_code_unit);
                    fails++;
                end else begin
                    want = units_due.pop_front();
                    if (i_code_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h", want.code_unit, i_code_unit);
                        fails++;
                    end
                    if (i_terminator !== want.term) begin
                        $error("terminator: expected %b, got %b", want.term, i_terminator);
                        fails++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, i_last_of_run);
                        fails++;
                    end
                end
            end
        end
        o_fail_count     <= fails;
        o_units_left     <= units_due.size();
        o_bytes_seen     <= bytes_seen;
        o_units_seen     <= units_seen;
        o_replacements   <= repl_seen;
        o_strings_closed <= strings_seen;
    end

endmodule

[dv/tb_utf8_to_utf16_decoder.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the UTF-8 to UTF-16 decoder. A directed string
// walks every sequence length, the overlong and surrogate rejects, the out of
// range four-byte case, a broken sequence, invalid leads and the zero-byte
// stop; then random strings, mostly well-formed with random content, mixed
// with truncated sequences, overlong forms, noise and zero bytes. The checker
// beside the block predicts and compares; this module only drives and judges.
module tb_utf8_to_utf16_decoder;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int RANDOM_BYTES   = 400;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [15:0] o_code_unit;
    logic        o_terminator;
    logic        o_last_of_run;

    int fail_count, units_left, bytes_seen, units_seen, replacements, strings_closed;
    int idle_cycles = 0;
    bit hold_req = 1'b0;      // sender asks the receiver for a long hold-off
    logic [7:0] text_q[$];    // bytes of the string being built

    always #10 i_clk = ~i_clk;

    utf8_to_utf16_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_code_unit     (o_code_unit),
        .o_terminator    (o_terminator),
        .o_last_of_run   (o_last_of_run)
    );

    utf16_unit_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_byte      (i_data_byte),
        .i_end_of_string  (i_end_of_string),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_code_unit      (o_code_unit),
        .i_terminator     (o_terminator),
        .i_last_of_run    (o_last_of_run),
        .o_fail_count     (fail_count),
        .o_units_left     (units_left),
        .o_bytes_seen     (bytes_seen),
        .o_units_seen     (units_seen),
        .o_replacements   (replacements),
        .o_strings_closed (strings_closed)
    );

    // Gap length: mostly none or short, now and then long. A steady phase
    // runs with no gaps at all.
    function automatic int pick_gap(bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Append the UTF-8 form of cp, len bytes long. Values out of the
    // Unicode range still get a four-byte shape.
    function automatic void add_cp(logic [20:0] cp, int len);
        case (len)
            1: text_q.push_back({1'b0, cp[6:0]});
            2: begin
                text_q.push_back({3'b110, cp[10:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                text_q.push_back({4'b1110, cp[15:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                text_q.push_back({5'b11110, cp[20:18]});
                text_q.push_back({2'b10, cp[17:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // One random piece of text: mostly well-formed characters of every
    // length, plus truncated sequences, overlong forms, noise and zero bytes.
    function automatic void add_random_piece();
        int roll;
        int len;
        logic [20:0] cp;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            add_cp(21'($urandom_range(1, 8'h7F)), 1);
        else if (roll < 45)
            add_cp(21'($urandom_range(16'h0080, 16'h07FF)), 2);
        else if (roll < 65) begin
            cp = ($urandom_range(0, 7) == 0) ? 21'($urandom_range(16'hD800, 16'hDFFF))
                                              : 21'($urandom_range(16'h0800, 16'hFFFF));
            add_cp(cp, 3);
        end else if (roll < 80) begin
            cp = ($urandom_range(0, 5) == 0) ? 21'($urandom_range(21'h110000, 21'h1FFFFF))
                                              : 21'($urandom_range(21'h010000, 21'h10FFFF));
            add_cp(cp, 4);
        end else if (roll < 88) begin
            // drop the tail of a good sequence so the next byte breaks it
            len = $urandom_range(2, 4);
            cp  = (len == 2) ? 21'($urandom_range(16'h0080, 16'h07FF))
                : (len == 3) ? 21'($urandom_range(16'h0800, 16'hFFFF))
                             : 21'($urandom_range(21'h010000, 21'h10FFFF));
            add_cp(cp, len);
            repeat ($urandom_range(1, len - 1))
                void'(text_q.pop_back());
        end else if (roll < 93) begin
            if ($urandom_range(0, 1)) begin
                text_q.push_back(8'hE0);
                text_q.push_back({3'b100, 5'($urandom_range(0, 31))});
            end else begin
                text_q.push_back(8'hF0);
                text_q.push_back({4'b1000, 4'($urandom_range(0, 15))});
            end
            text_q.push_back({2'b10, 6'($urandom_range(0, 63))});
        end else if (roll < 98)
            text_q.push_back(8'($urandom_range(0, 255)));
        else
            text_q.push_back(8'h00);
    endfunction

    // Drive one byte request and hold it until the block takes it.
    task automatic send_byte(logic [7:0] b, logic eos);
        push            <= 1'b1;
        i_data_byte     <= b;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (full);
    endtask

    // Send the built string, flagging end of string on its last byte if
    // asked, with random gaps between requests.
    task automatic send_text(bit close_string, bit steady);
        int n;
        foreach (text_q[i]) begin
            send_byte(text_q[i], close_string && (i == text_q.size() - 1));
            n = pick_gap(steady);
            if (n > 0) begin
                push <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
        text_q.delete();
    endtask

    // Sender: reset, directed string, then random strings.
    initial begin
        int  random_sent;
        int  strings_sent;
        int  pieces;
        bit  steady;
        random_sent  = 0;
        strings_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two-, three- and four-byte characters at their edges, an encoded
        // surrogate, a four-byte value past U+10FFFF, overlong E0 and F0
        // forms (the breaking byte is then an invalid lead), and a sequence
        // broken after two continuations with end of string on the breaker:
        // that last byte causes the most units a byte can.
        text_q = '{8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'h80,
                   8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                   8'hE0, 8'h80, 8'hF0, 8'h8F, 8'hF1, 8'h80, 8'h80, 8'h41};
        send_text(1'b1, 1'b0);
        // Zero byte with a lead pending: flush, stop, ignore until the end.
        text_q = '{8'hC3, 8'h00, 8'hFF};
        send_text(1'b1, 1'b0);

        while (random_sent < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 3) == 0);
            pieces = $urandom_range(1, 10);
            if (strings_sent == 8) begin
                // Fill the block while the receiver holds off.
                hold_req = 1'b1;
                steady   = 1'b1;
                pieces   = 16;
            end
            if (strings_sent == 20) begin
                // Pause until every expected unit has come out.
                push <= 1'b0;
                @(posedge i_clk);
                wait (units_left == 0);
                @(posedge i_clk);
            end
            repeat (pieces)
                add_random_piece();
            random_sent += text_q.size();
            send_text($urandom_range(0, 99) < 85, steady);
            strings_sent++;
        end

        push <= 1'b0;
        @(posedge i_clk);
        wait (units_left == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d bytes in, %0d code units out over %0d closed strings",
                 bytes_seen, units_seen, strings_closed);
        $display("tb: %0d replacement units, directed and %0d random bytes",
                 replacements, random_sent);
        if (fail_count == 0 && units_left == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: pop with random stalls, steady stretches, and one long
    // hold-off when the sender asks for it.
    initial begin
        int n;
        int pops;
        bit steady_pop;
        pops       = 0;
        steady_pop = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = pick_gap(steady_pop);
                if (n > 0) begin
                    pop <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            pops++;
            if (pops % 64 == 0)
                steady_pop = ~steady_pop;
        end
    end

    // Watchdog: end the run if no request moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
